@@ hw/rtl/psg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, codes and constants of the tone/noise sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int MAX_TICKS_DEFAULT = 64;

  localparam int STEP_W   = 22;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = STEP_W + 1;
  localparam int TICKS_W  = ACC_W - FRAC_W;
  localparam int PERIOD_W = 10;
  localparam int ATTEN_W  = 4;
  localparam int NMODE_W  = 3;
  localparam int LFSR_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 13;
  localparam int SUM_W    = 18;

  localparam logic [STEP_W-1:0]   TICK_STEP_RESET = 22'd332464;
  localparam logic [LFSR_W-1:0]   LFSR_SEED       = 16'h8000;
  localparam logic [PERIOD_W-1:0] NOISE_BASE      = 10'h010;
  localparam logic [1:0]          NOISE_CH        = 2'd3;
  localparam logic [1:0]          RATE_TONE2      = 2'd3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 18'sd32767;
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -18'sd32768;

  typedef struct packed {
    logic write_byte;
    logic start_sample;
    logic run_tick;
    logic load_out;
  } psg_cmd_t;

  typedef struct packed {
    logic ticks_zero;
  } psg_status_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [ATTEN_W-1:0] a);
    logic [LEVEL_W-1:0] r;
    unique case (a)
      4'd0:    r = 13'd7000;
      4'd1:    r = 13'd4416;
      4'd2:    r = 13'd2786;
      4'd3:    r = 13'd1758;
      4'd4:    r = 13'd1109;
      4'd5:    r = 13'd700;
      4'd6:    r = 13'd441;
      4'd7:    r = 13'd278;
      4'd8:    r = 13'd175;
      4'd9:    r = 13'd110;
      4'd10:   r = 13'd70;
      4'd11:   r = 13'd44;
      4'd12:   r = 13'd27;
      4'd13:   r = 13'd17;
      4'd14:   r = 13'd11;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/psg_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_in_if
// Request channel: register byte write or sample request.
// ----------------------------------------------------------------------------
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/psg_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_out_if
// Sample channel: one signed 16-bit mixed sample per word.
// ----------------------------------------------------------------------------
interface psg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/psg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_ctrl
// Sequencer: accepts requests, steps the tick loop, hands off the mix.
// ----------------------------------------------------------------------------
module psg_ctrl
  import psg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_action,
  output logic             req_ready,
  input  wire logic        out_ready,
  output logic             out_valid,
  input  wire psg_status_t status,
  output psg_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_MIX  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_action == ACT_SAMPLE) begin
            cmd.start_sample = 1'b1;
            state_next       = ST_TICK;
          end else begin
            cmd.write_byte = 1'b1;
          end
        end
      end
      ST_TICK: begin
        if (status.ticks_zero) begin
          state_next = ST_MIX;
        end else begin
          cmd.run_tick = 1'b1;
        end
      end
      ST_MIX: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/psg_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_dp
// Datapath: registers, tone and noise counters, LFSR, mixer, sample word.
// ----------------------------------------------------------------------------
module psg_dp
  import psg_pkg::*;
#(
  parameter int MAX_TICKS_PER_SAMPLE = MAX_TICKS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [STEP_W-1:0]          cfg_wr_data,
  input  wire logic [7:0]                 data_byte,
  input  wire psg_cmd_t                   cmd,
  output psg_status_t                     status,
  output logic signed [SAMPLE_W-1:0]      sample
);

  localparam int CNT_W = $clog2(MAX_TICKS_PER_SAMPLE + 1);

  logic [STEP_W-1:0]   tick_step;
  logic [FRAC_W-1:0]   phase;
  logic [CNT_W-1:0]    ticks_left;
  logic [PERIOD_W-1:0] tone_period [3];
  logic [PERIOD_W-1:0] chan_cnt    [4];
  logic [ATTEN_W-1:0]  atten       [4];
  logic [3:0]          level;
  logic [LFSR_W-1:0]   lfsr;
  logic [NMODE_W-1:0]  noise_ctl;
  logic [1:0]          latch_ch;
  logic                latch_vol;

  logic [ACC_W-1:0]    acc;
  logic [TICKS_W-1:0]  ticks;
  logic [CNT_W-1:0]    ticks_capped;

  logic [1:0]          wr_ch;
  logic                wr_vol;
  logic [PERIOD_W-1:0] wr_old;
  logic [PERIOD_W-1:0] wr_period;

  logic [PERIOD_W-1:0] chan_cnt_next [4];
  logic [3:0]          level_next;
  logic [LFSR_W-1:0]   lfsr_next;
  logic                fb;

  logic signed [SUM_W-1:0] mix_sum;
  logic signed [SUM_W-1:0] mix_sat;

  assign acc          = ACC_W'(phase) + ACC_W'(tick_step);
  assign ticks        = acc[ACC_W-1:FRAC_W];
  assign ticks_capped = (32'(ticks) > 32'(MAX_TICKS_PER_SAMPLE)) ?
                        CNT_W'(MAX_TICKS_PER_SAMPLE) : CNT_W'(ticks);
  assign status.ticks_zero = (ticks_left == '0);

  always_comb begin
    wr_ch  = data_byte[7] ? data_byte[6:5] : latch_ch;
    wr_vol = data_byte[7] ? data_byte[4]   : latch_vol;
    unique case (wr_ch)
      2'd0:    wr_old = tone_period[0];
      2'd1:    wr_old = tone_period[1];
      default: wr_old = tone_period[2];
    endcase
    if (data_byte[7]) begin
      wr_period = {wr_old[9:4], data_byte[3:0]};
    end else begin
      wr_period = {data_byte[5:0], wr_old[3:0]};
    end
    if (wr_period == '0) begin
      wr_period = PERIOD_W'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (chan_cnt[i] <= PERIOD_W'(1)) begin
        chan_cnt_next[i] = tone_period[i];
        level_next[i]    = (tone_period[i] > PERIOD_W'(1)) ? ~level[i] : 1'b1;
      end else begin
        chan_cnt_next[i] = chan_cnt[i] - PERIOD_W'(1);
        level_next[i]    = level[i];
      end
    end
    fb = noise_ctl[2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
    if (chan_cnt[3] <= PERIOD_W'(1)) begin
      if (noise_ctl[1:0] == RATE_TONE2) begin
        chan_cnt_next[3] = tone_period[2];
      end else begin
        chan_cnt_next[3] = NOISE_BASE << noise_ctl[1:0];
      end
      lfsr_next     = {fb, lfsr[LFSR_W-1:1]};
      level_next[3] = lfsr[1];
    end else begin
      chan_cnt_next[3] = chan_cnt[3] - PERIOD_W'(1);
      lfsr_next        = lfsr;
      level_next[3]    = level[3];
    end
  end

  always_comb begin
    mix_sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (level[i]) begin
        mix_sum = mix_sum + SUM_W'(level_of(atten[i]));
      end else begin
        mix_sum = mix_sum - SUM_W'(level_of(atten[i]));
      end
    end
    priority if (mix_sum > SAMPLE_MAX) begin
      mix_sat = SAMPLE_MAX;
    end else if (mix_sum < SAMPLE_MIN) begin
      mix_sat = SAMPLE_MIN;
    end else begin
      mix_sat = mix_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step  <= TICK_STEP_RESET;
      phase      <= '0;
      ticks_left <= '0;
      for (int i = 0; i < 3; i++) begin
        tone_period[i] <= PERIOD_W'(1);
      end
      for (int i = 0; i < 4; i++) begin
        chan_cnt[i] <= PERIOD_W'(1);
        atten[i]    <= '1;
      end
      level     <= '0;
      lfsr      <= LFSR_SEED;
      noise_ctl <= '0;
      latch_ch  <= '0;
      latch_vol <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tick_step <= cfg_wr_data;
      end
      if (cmd.write_byte) begin
        if (data_byte[7]) begin
          latch_ch  <= data_byte[6:5];
          latch_vol <= data_byte[4];
        end
        if (wr_vol) begin
          atten[wr_ch] <= data_byte[3:0];
        end else if (wr_ch == NOISE_CH) begin
          noise_ctl <= data_byte[2:0];
          lfsr      <= LFSR_SEED;
        end else begin
          tone_period[wr_ch] <= wr_period;
        end
      end
      if (cmd.start_sample) begin
        phase      <= acc[FRAC_W-1:0];
        ticks_left <= ticks_capped;
      end
      if (cmd.run_tick) begin
        chan_cnt   <= chan_cnt_next;
        level      <= level_next;
        lfsr       <= lfsr_next;
        ticks_left <= ticks_left - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample <= mix_sat[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/psg_tone_noise_generator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_unit
// Three square-wave tone channels and one LFSR noise channel, mixed to one
// signed 16-bit sample.
//
// req: valid/ready words. action 0 writes data_byte through the latch/data
//   register protocol and gives no result; action 1 asks for one sample.
// smp: one signed 16-bit sample word per sample request, in request order.
// cfg_wr_en/cfg_wr_data: write tick_step (unsigned 6.16 internal ticks per
//   sample) at any clock edge with cfg_wr_en high.
// A sample request runs N internal ticks before its sample word is loaded,
// where N is the whole number of ticks of the 7.16 phase accumulator,
// capped at MAX_TICKS_PER_SAMPLE; one internal tick runs per cycle through
// the shared counter/LFSR datapath.
// Requests are taken one at a time; req is ready again once the sample is
// loaded into the output register.
// A stalled receiver holds the sample word; the next request is still taken
// and its sample waits in the mixer until the output register frees up.
// Reset (rst, synchronous) silences all channels, sets periods and counters
// to 1, seeds the LFSR with 0x8000 and restores tick_step to 332464.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator_unit
  import psg_pkg::*;
#(
  parameter int MAX_TICKS_PER_SAMPLE = MAX_TICKS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  psg_in_if.sink                 req,
  psg_out_if.source              smp,
  input  wire logic              cfg_wr_en,
  input  wire logic [STEP_W-1:0] cfg_wr_data
);

  psg_cmd_t    cmd;
  psg_status_t status;
  logic        req_ready;
  logic        out_valid;
  logic signed [SAMPLE_W-1:0] sample;

  psg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req_ready),
    .out_ready  (smp.ready),
    .out_valid  (out_valid),
    .status     (status),
    .cmd        (cmd)
  );

  psg_dp #(
    .MAX_TICKS_PER_SAMPLE (MAX_TICKS_PER_SAMPLE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_byte   (req.data_byte),
    .cmd         (cmd),
    .status      (status),
    .sample      (sample)
  );

  assign req.ready  = req_ready;
  assign smp.valid  = out_valid;
  assign smp.sample = sample;

endmodule
`default_nettype wire
